// File: hw/rtl/lmb_pkg.sv
// Shared constants, types and register codes of the 3x3 local-mean binarizer.
package lmb_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int PIXEL_BITS = 8;

	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = 16;
	localparam int WCFG_W   = 12;
	localparam int HCFG_W   = 16;
	localparam int CSUM_W   = PIXEL_BITS + 2;
	localparam int SUM_W    = PIXEL_BITS + 4;

	localparam int RUN_DEPTH = 8;
	localparam int RUN_PTR_W = $clog2(RUN_DEPTH);

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [WCFG_W-1:0] WIDTH_RESET  = WCFG_W'(2048);
	localparam logic [HCFG_W-1:0] HEIGHT_RESET = HCFG_W'(2048);

	// Result slots of one run, in the order they are delivered.
	localparam int SLOT_UL = 0;
	localparam int SLOT_UR = 1;
	localparam int SLOT_LL = 2;
	localparam int SLOT_LR = 3;
	localparam int SLOTS   = 4;

	typedef logic [PIXEL_BITS-1:0] pix_t;
	typedef pix_t [2:0][2:0] win_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last_col;
		logic             last_row;
		logic             has_res;
	} pos_t;

	typedef struct packed {
		logic [SLOTS-1:0] mask;
		logic [SLOTS-1:0] bits;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} run_t;

endpackage

// File: hw/rtl/lmb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lmb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/lmb_judge.sv
// Two-stage neighborhood sum and threshold compare for the four result slots of a run.
module lmb_judge (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s2,
	input  lmb_pkg::pos_t pos_s2,
	input  lmb_pkg::win_t win,
	output logic          valid_s3,
	output lmb_pkg::run_t run_s3
);
	import lmb_pkg::*;

	logic [CSUM_W-1:0] col_a [3];
	logic [CSUM_W-1:0] col_b [3];
	logic [2:0][PIXEL_BITS-1:0] up_row;

	logic [CSUM_W-1:0] a_lf_s3, a1_s3, a2_s3, b_lf_s3, b1_s3, b2_s3;
	pix_t [SLOTS-1:0]  ctr_s3;
	logic [SLOTS-1:0]  mask_s3;
	logic [ROW_W-1:0]  row_s3;
	logic [COL_W-1:0]  col_s3;

	logic [SUM_W-1:0] sum [SLOTS];
	logic [SUM_W-1:0] nine [SLOTS];
	logic [SLOTS-1:0] bits;

	// Column sums with the row above replicated on the top row of the frame.
	always_comb begin
		up_row = (pos_s2.row == ROW_W'(1)) ? win[1] : win[0];
		for (int j = 0; j < 3; j++) begin
			col_a[j] = CSUM_W'(up_row[j]) + CSUM_W'(win[1][j]) + CSUM_W'(win[2][j]);
			col_b[j] = CSUM_W'(win[1][j]) + {1'b0, win[2][j], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			a_lf_s3 <= (pos_s2.col == COL_W'(1)) ? col_a[1] : col_a[0];
			b_lf_s3 <= (pos_s2.col == COL_W'(1)) ? col_b[1] : col_b[0];
			a1_s3   <= col_a[1];
			a2_s3   <= col_a[2];
			b1_s3   <= col_b[1];
			b2_s3   <= col_b[2];
			ctr_s3[SLOT_UL] <= win[1][1];
			ctr_s3[SLOT_UR] <= win[1][2];
			ctr_s3[SLOT_LL] <= win[2][1];
			ctr_s3[SLOT_LR] <= win[2][2];
			mask_s3[SLOT_UL] <= pos_s2.has_res;
			mask_s3[SLOT_UR] <= pos_s2.has_res & pos_s2.last_col;
			mask_s3[SLOT_LL] <= pos_s2.has_res & pos_s2.last_row;
			mask_s3[SLOT_LR] <= pos_s2.has_res & pos_s2.last_col & pos_s2.last_row;
			row_s3 <= pos_s2.row;
			col_s3 <= pos_s2.col;
		end
	end

	// Right column is replicated for the slots on the last column.
	always_comb begin
		sum[SLOT_UL] = SUM_W'(a_lf_s3) + SUM_W'(a1_s3) + SUM_W'(a2_s3);
		sum[SLOT_UR] = SUM_W'(a1_s3) + {1'b0, a2_s3, 1'b0};
		sum[SLOT_LL] = SUM_W'(b_lf_s3) + SUM_W'(b1_s3) + SUM_W'(b2_s3);
		sum[SLOT_LR] = SUM_W'(b1_s3) + {1'b0, b2_s3, 1'b0};
		for (int k = 0; k < SLOTS; k++) begin
			nine[k] = {1'b0, ctr_s3[k], 3'b000} + SUM_W'(ctr_s3[k]);
			bits[k] = nine[k] > sum[k];
		end
	end

	assign run_s3.mask = mask_s3;
	assign run_s3.bits = bits;
	assign run_s3.row  = row_s3;
	assign run_s3.col  = col_s3;

endmodule

// File: hw/rtl/lmb_run_fifo.sv
// Run buffer and result sequencer, delivering a result beat per cycle unless stalled.
module lmb_run_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  lmb_pkg::run_t                push_run,
	output logic [lmb_pkg::RUN_PTR_W:0]  count,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic                         above_mean,
	output logic [lmb_pkg::ROW_W-1:0]    out_row,
	output logic [lmb_pkg::COL_W-1:0]    out_col,
	output logic                         last_of_run,
	output logic                         frame_done
);
	import lmb_pkg::*;

	run_t                 runs_q [RUN_DEPTH];
	logic [RUN_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [RUN_PTR_W:0]   count_q;
	logic [SLOTS-1:0]     done_q;

	run_t             head;
	logic [SLOTS-1:0] rem, cur, after;
	logic             do_push, beat, pop;

	assign head      = runs_q[rd_ptr_q];
	assign rem       = head.mask & ~done_q;
	assign do_push   = push & (|push_run.mask);
	assign res_valid = count_q != '0;
	assign count     = count_q;

	always_comb begin
		cur = '0;
		priority if (rem[SLOT_UL]) begin
			cur[SLOT_UL] = 1'b1;
		end else if (rem[SLOT_UR]) begin
			cur[SLOT_UR] = 1'b1;
		end else if (rem[SLOT_LL]) begin
			cur[SLOT_LL] = 1'b1;
		end else if (rem[SLOT_LR]) begin
			cur[SLOT_LR] = 1'b1;
		end else begin
			cur = '0;
		end
	end

	assign after       = rem & ~cur;
	assign beat        = res_valid & ~res_stall;
	assign pop         = beat & (after == '0);
	assign last_of_run = after == '0;
	assign frame_done  = cur[SLOT_LR];
	assign above_mean  = |(cur & head.bits);
	assign out_row     = (cur[SLOT_UL] | cur[SLOT_UR]) ? head.row - ROW_W'(1) : head.row;
	assign out_col     = (cur[SLOT_UL] | cur[SLOT_LL]) ? head.col - COL_W'(1) : head.col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			done_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + RUN_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RUN_PTR_W'(1);
				done_q   <= '0;
			end else if (beat) begin
				done_q <= done_q | cur;
			end
			if (do_push && !pop) begin
				count_q <= count_q + (RUN_PTR_W + 1)'(1);
			end else if (pop && !do_push) begin
				count_q <= count_q - (RUN_PTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			runs_q[wr_ptr_q] <= push_run;
		end
	end

endmodule

// File: hw/rtl/local_mean_binarize_3x3.sv
// Top level of the streaming 3x3 local-mean binarizer.
// The block takes one pixel per clock in raster order and marks each pixel whose value,
// times nine, exceeds the sum of its 3x3 neighborhood (itself included), with the image
// border replicated. A result for pixel (r,c) comes out once pixel (r+1,c+1) has been
// taken; a pixel on the last column also releases the result directly above it, and on
// the last row of the frame the row below is replicated, so one pixel releases up to four
// results, delivered one beat per clock unless stalled. The two previous image rows are
// kept in two 2048 x 8 line RAMs, each read once and written once per pixel, which is
// what sets the sustained rate of one pixel per clock. Results travel through a
// read-modify-write stage, two sum and compare stages and an eight-run output buffer.
// The input stalls only while the output buffer and the three working stages could not
// hold another run, which happens when the consumer stalls or during the two- and
// four-result bursts at row and frame ends. The line RAMs need no clearing after
// reset: unwritten entries only ever land in window positions that border replication
// discards. image_width is used clamped to 2..2048 and image_height to at least 2;
// both should be written only while the block is idle. If they shrink mid-frame, the
// position counters wrap to the next row or to row zero.
module local_mean_binarize_3x3 (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lmb_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [lmb_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [lmb_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	input  logic                               pix_valid,
	output logic                               pix_stall,
	input  logic [lmb_pkg::PIXEL_BITS-1:0]     pixel,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic                               above_mean,
	output logic [lmb_pkg::ROW_W-1:0]          out_row,
	output logic [lmb_pkg::COL_W-1:0]          out_col,
	output logic                               last_of_run,
	output logic                               frame_done
);
	import lmb_pkg::*;

	// Configuration registers.
	logic [WCFG_W-1:0] cfg_width_q;
	logic [HCFG_W-1:0] cfg_height_q;
	logic              reg_idx;
	logic              cfg_wr;

	// Position counters.
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// Effective sizes and position of the pixel being taken.
	logic [COL_W:0]   w_eff;
	logic [ROW_W-1:0] h_eff;
	logic             col_wrap, end_row, end_frame;
	logic [ROW_W:0]   r_pre, r_next;
	logic [COL_W:0]   c_next;
	logic [COL_W-1:0] c0;
	logic [ROW_W-1:0] r0;
	pos_t             pos0;
	logic             accept;

	// Pipeline.
	logic  valid_s1, valid_s2, valid_s3;
	pos_t  pos_s1, pos_s2;
	pix_t  px_s1;
	pix_t  l1_rd, l2_rd;
	win_t  window_q;
	run_t  run_s3;
	logic [RUN_PTR_W:0]   run_count;
	logic [RUN_PTR_W+1:0] occupancy;

	// APB slave: no wait states (pready tied high), registers decoded on the word index.
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_comb begin
		unique case (reg_idx)
			REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(cfg_width_q);
			REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(cfg_height_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= WIDTH_RESET;
			cfg_height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_IMAGE_WIDTH:  cfg_width_q  <= pwdata[WCFG_W-1:0];
				REG_IMAGE_HEIGHT: cfg_height_q <= pwdata[HCFG_W-1:0];
				default:          cfg_width_q  <= cfg_width_q;
			endcase
		end
	end

	// Clamp the programmed sizes to what the line RAMs and the window support.
	always_comb begin
		if (int'(cfg_width_q) > MAX_WIDTH) begin
			w_eff = (COL_W + 1)'(MAX_WIDTH);
		end else if (cfg_width_q < WCFG_W'(2)) begin
			w_eff = (COL_W + 1)'(2);
		end else begin
			w_eff = (COL_W + 1)'(cfg_width_q);
		end
		h_eff = (cfg_height_q < HCFG_W'(2)) ? ROW_W'(2) : ROW_W'(cfg_height_q);
	end

	// Position of the incoming pixel. The counters are rechecked against the current
	// sizes first, so a size change between frames or mid-frame wraps cleanly.
	always_comb begin
		col_wrap  = {1'b0, col_q} >= w_eff;
		c0        = col_wrap ? '0 : col_q;
		r_pre     = col_wrap ? {1'b0, row_q} + (ROW_W + 1)'(1) : {1'b0, row_q};
		r0        = (r_pre >= {1'b0, h_eff}) ? '0 : r_pre[ROW_W-1:0];
		c_next    = {1'b0, c0} + (COL_W + 1)'(1);
		r_next    = {1'b0, r0} + (ROW_W + 1)'(1);
		end_row   = c_next >= w_eff;
		end_frame = r_next >= {1'b0, h_eff};

		pos0.row      = r0;
		pos0.col      = c0;
		pos0.last_col = c_next == w_eff;
		pos0.last_row = r_next == {1'b0, h_eff};
		pos0.has_res  = (r0 != '0) && (c0 != '0);
	end

	// Stall while every run that might still arrive would not fit into the run buffer.
	assign occupancy = (RUN_PTR_W + 2)'(run_count) + (RUN_PTR_W + 2)'(valid_s1)
	                 + (RUN_PTR_W + 2)'(valid_s2) + (RUN_PTR_W + 2)'(valid_s3);
	assign pix_stall = occupancy >= (RUN_PTR_W + 2)'(RUN_DEPTH);
	assign accept    = pix_valid & ~pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			if (accept) begin
				if (end_row) begin
					col_q <= '0;
					row_q <= end_frame ? '0 : r_next[ROW_W-1:0];
				end else begin
					col_q <= c_next[COL_W-1:0];
					row_q <= r0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1 <= pos0;
			px_s1  <= pixel;
		end
		if (valid_s1) begin
			pos_s2 <= pos_s1;
		end
	end

	// Line RAMs: read at the column of the pixel being taken, written back in the following
	// cycle. Consecutive pixels never share a column, and a column comes back no sooner
	// than two pixels later, so a read never meets a pending write to its own entry.
	lmb_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_line_above (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (pos_s1.col),
		.wdata (px_s1),
		.re    (accept),
		.raddr (c0),
		.rdata (l1_rd)
	);

	lmb_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_line_two_above (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (pos_s1.col),
		.wdata (l1_rd),
		.re    (accept),
		.raddr (c0),
		.rdata (l2_rd)
	);

	// The 3x3 window shifts left and takes the new column: two rows from the line
	// RAMs and the pixel itself at the bottom.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int i = 0; i < 3; i++) begin
				window_q[i][0] <= window_q[i][1];
				window_q[i][1] <= window_q[i][2];
			end
			window_q[0][2] <= l2_rd;
			window_q[1][2] <= l1_rd;
			window_q[2][2] <= px_s1;
		end
	end

	lmb_judge u_judge (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.pos_s2   (pos_s2),
		.win      (window_q),
		.valid_s3 (valid_s3),
		.run_s3   (run_s3)
	);

	lmb_run_fifo u_run_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (valid_s3),
		.push_run    (run_s3),
		.count       (run_count),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.above_mean  (above_mean),
		.out_row     (out_row),
		.out_col     (out_col),
		.last_of_run (last_of_run),
		.frame_done  (frame_done)
	);

endmodule

// File: hw/rtl/lmb_checker.sv
// Port-level checker for the 3x3 local-mean binarizer, bound to the top level.
module lmb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           res_valid,
	input logic                           res_stall,
	input logic                           above_mean,
	input logic [lmb_pkg::ROW_W-1:0]      out_row,
	input logic [lmb_pkg::COL_W-1:0]      out_col,
	input logic                           last_of_run,
	input logic                           frame_done
);

	// A stalled result beat stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result beat withdrawn while stalled");

	// A stalled result beat keeps its payload.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=>
		$stable({above_mean, out_row, out_col, last_of_run, frame_done}))
		else $error("result payload changed while stalled");

	// The rest of a run is already buffered, so it follows without a gap.
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !last_of_run |=> res_valid)
		else $error("gap inside a run of results");

	// The bottom right pixel closes its run and has a nonzero row and column.
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_done |-> last_of_run && (out_row != '0) && (out_col != '0))
		else $error("frame end on a bad result beat");

endmodule

bind local_mean_binarize_3x3 lmb_checker u_lmb_checker (.*);

// File: sim/tb_local_mean_binarize_3x3.sv
// Self-checking testbench for the streaming 3x3 local-mean binarizer.
module tb_local_mean_binarize_3x3;

	import lmb_pkg::*;

	// Nine taps in the window: a pixel is marked when nine times its value beats their sum.
	localparam int unsigned WINDOW_TAPS = 9;
	// Cycles allowed after the last expected beat for anything still in the pipeline.
	localparam int DRAIN_CYCLES = 16;
	// Cycles without any accepted beat before the run is declared hung.
	localparam int QUIET_LIMIT = 3000;
	localparam int RANDOM_PIXELS = 90;
	localparam int REPORT_LIMIT = 50;

	// One result beat as it leaves the block.
	typedef struct packed {
		logic             above;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
		logic             done;
	} bin_result_t;

	typedef enum int {PIX_ANY, PIX_EXTREME, PIX_FLAT} pixel_style_e;
	typedef enum int {SINK_FLOW, SINK_CHOPPY, SINK_BLOCKY} sink_mode_e;

	// The scoreboard keeps its own copy of the line buffers, the window, the position
	// counters and the size registers, and predicts the result beats of every pixel.
	class binarize_scoreboard;
		logic [WCFG_W-1:0] width_reg;
		logic [HCFG_W-1:0] height_reg;
		pix_t line_above [MAX_WIDTH];
		pix_t line_two_above [MAX_WIDTH];
		pix_t win [3][3];
		int unsigned col_cnt;
		int unsigned row_cnt;
		bin_result_t awaited_results[$];
		int mismatches;

		function new();
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			foreach (line_above[i]) begin
				line_above[i] = '0;
				line_two_above[i] = '0;
			end
			foreach (win[i, j]) win[i][j] = '0;
			col_cnt = 0;
			row_cnt = 0;
			mismatches = 0;
		endfunction

		function void set_register(logic idx, logic [APB_DATA_W-1:0] value);
			if (idx == REG_IMAGE_WIDTH) width_reg = value[WCFG_W-1:0];
			else height_reg = value[HCFG_W-1:0];
		endfunction

		function int unsigned eff_width();
			if (width_reg < 2) return 2;
			if (width_reg > MAX_WIDTH) return MAX_WIDTH;
			return width_reg;
		endfunction

		function int unsigned eff_height();
			return (height_reg < 2) ? 2 : height_reg;
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		function bit at_origin();
			return col_cnt == 0 && row_cnt == 0;
		endfunction

		// Pixels still to come before the counters return to the top left corner.
		function int unsigned pixels_to_frame_end();
			int unsigned w, h, c, r;
			w = eff_width();
			h = eff_height();
			c = col_cnt;
			r = row_cnt;
			if (c >= w) begin
				c = 0;
				r++;
			end
			if (r >= h) r = 0;
			return (h - r) * w - c;
		endfunction

		// Threshold decision for the window entry (wi, wj) at image position (rr, cc).
		// Missing rows and columns at the border fall back to the centre row or column.
		function logic judge(int wi, int wj, int unsigned rr, int unsigned cc);
			int tap_row[3];
			int tap_col[3];
			int unsigned total;
			tap_row[0] = (rr == 0) ? wi : wi - 1;
			tap_row[1] = wi;
			tap_row[2] = (wi == 2) ? 2 : wi + 1;
			tap_col[0] = (cc == 0) ? wj : wj - 1;
			tap_col[1] = wj;
			tap_col[2] = (wj == 2) ? 2 : wj + 1;
			total = 0;
			for (int a = 0; a < 3; a++)
				for (int b = 0; b < 3; b++)
					total += win[tap_row[a]][tap_col[b]];
			return (WINDOW_TAPS * win[wi][wj] > total);
		endfunction

		function bin_result_t make_result(int wi, int wj, int unsigned rr, int unsigned cc,
						  int unsigned w, int unsigned h);
			bin_result_t res;
			res.above = judge(wi, wj, rr, cc);
			res.row = ROW_W'(rr);
			res.col = COL_W'(cc);
			res.last = 1'b0;
			res.done = (rr == h - 1 && cc == w - 1);
			return res;
		endfunction

		function void note_pixel(pix_t px);
			int unsigned w, h, r, c;
			bin_result_t run [SLOTS];
			int n;
			w = eff_width();
			h = eff_height();
			if (col_cnt >= w) begin
				col_cnt = 0;
				row_cnt++;
			end
			if (row_cnt >= h) row_cnt = 0;
			r = row_cnt;
			c = col_cnt;
			for (int i = 0; i < 3; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2] = line_two_above[c];
			win[1][2] = line_above[c];
			win[2][2] = px;
			line_two_above[c] = line_above[c];
			line_above[c] = px;

			// The pixel up and to the left is now complete; the last column and the
			// last row also release their replicated neighbours.
			n = 0;
			if (r >= 1 && c >= 1) begin
				run[n] = make_result(1, 1, r - 1, c - 1, w, h);
				n++;
				if (c == w - 1) begin
					run[n] = make_result(1, 2, r - 1, c, w, h);
					n++;
				end
				if (r == h - 1) begin
					run[n] = make_result(2, 1, r, c - 1, w, h);
					n++;
					if (c == w - 1) begin
						run[n] = make_result(2, 2, r, c, w, h);
						n++;
					end
				end
				run[n - 1].last = 1'b1;
			end
			for (int i = 0; i < n; i++) awaited_results.push_back(run[i]);

			col_cnt = c + 1;
			if (col_cnt >= w) begin
				col_cnt = 0;
				row_cnt = r + 1;
				if (row_cnt >= h) row_cnt = 0;
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				if (mismatches < REPORT_LIMIT)
					$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(bin_result_t got);
			bin_result_t want;
			if (awaited_results.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$display("%0t: result beat with none expected, row %0d col %0d",
						 $time, got.row, got.col);
				mismatches++;
				return;
			end
			want = awaited_results.pop_front();
			compare_field("above_mean", want.above, got.above);
			compare_field("out_row", want.row, got.row);
			compare_field("out_col", want.col, got.col);
			compare_field("last_of_run", want.last, got.last);
			compare_field("frame_done", want.done, got.done);
		endfunction
	endclass

	// Directed frames: a 2x2 frame (both sizes written below the minimum) three times,
	// with a lone bright corner, a lone dark corner and a flat field where nine times
	// the centre equals the sum; then a 4x3 frame of alternating extremes and a ramp.
	localparam pix_t DIRECTED_TINY [12] = '{
		8'd255, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd255, 8'd255, 8'd255,
		8'd128, 8'd128, 8'd128, 8'd128
	};
	localparam pix_t DIRECTED_4X3 [12] = '{
		8'd0, 8'd255, 8'd0, 8'd255,
		8'd255, 8'd0, 8'd255, 8'd0,
		8'd1, 8'd2, 8'd3, 8'd254
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic pix_valid = 1'b0;
	logic pix_stall;
	pix_t pixel = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic above_mean;
	logic [ROW_W-1:0] out_row;
	logic [COL_W-1:0] out_col;
	logic last_of_run;
	logic frame_done;

	binarize_scoreboard sb = new();
	pix_t pixel_queue[$];
	pix_t flat_level = '0;
	int quiet_cycles = 0;
	sink_mode_e sink_mode = SINK_FLOW;
	int sink_mode_left = 0;

	local_mean_binarize_3x3 u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pixel(pixel),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.above_mean(above_mean),
		.out_row(out_row),
		.out_col(out_col),
		.last_of_run(last_of_run),
		.frame_done(frame_done)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Result side. Outputs are sampled right after the rising edge, before any
	// nonblocking update of that edge lands, so they hold the values the edge saw.
	// The stall pattern switches between free flow, frequent random stalls and
	// long blocked stretches, each held for a random number of cycles.
	always @(posedge clk) begin
		if (res_valid === 1'b1 && res_stall == 1'b0)
			sb.check_result('{above: above_mean, row: out_row, col: out_col,
					  last: last_of_run, done: frame_done});
		if ((res_valid === 1'b1 && res_stall == 1'b0) ||
		    (pix_valid == 1'b1 && pix_stall === 1'b0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (sink_mode_left == 0) begin
			sink_mode = sink_mode_e'($urandom_range(0, 2));
			sink_mode_left = $urandom_range(20, 150);
		end else begin
			sink_mode_left--;
		end
		case (sink_mode)
			SINK_FLOW: res_stall <= 1'b0;
			SINK_CHOPPY: res_stall <= ($urandom_range(0, 2) == 0);
			default: res_stall <= ($urandom_range(0, 7) == 0) ? ~res_stall : res_stall;
		endcase
	end

	// A hung handshake shows up as a long stretch with no beat accepted on either side.
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("tb: failure");
		$finish;
	end

	function automatic pix_t next_pixel(pixel_style_e style);
		case (style)
			PIX_EXTREME: return ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
			// Near-flat areas sit right at the threshold, where nine times the centre
			// and the window sum are equal or differ by a few counts.
			PIX_FLAT: return flat_level ^ pix_t'($urandom_range(0, 3) == 0);
			default: return pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void queue_pixels(int count, pixel_style_e style);
		for (int i = 0; i < count; i++) pixel_queue.push_back(next_pixel(style));
	endfunction

	// APB write: setup cycle, then access until pready; the register takes the value
	// at the edge where psel, penable, pwrite and pready are all high.
	task automatic write_register(logic idx, logic [APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_register(idx, value);
	endtask

	// Sends every queued pixel in bursts of random length. Most bursts end in a gap
	// of a few cycles, some run straight into the next one. A beat is taken at the
	// edge where valid is high and stall is low; the payload holds while stalled.
	task automatic send_pixels();
		int burst_left;
		pix_t px;
		burst_left = $urandom_range(1, 24);
		while (pixel_queue.size() != 0) begin
			px = pixel_queue.pop_front();
			pix_valid <= 1'b1;
			pixel <= px;
			@(posedge clk);
			while (pix_stall !== 1'b0) @(posedge clk);
			sb.note_pixel(px);
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				if ($urandom_range(0, 3) != 0) begin
					pix_valid <= 1'b0;
					repeat ($urandom_range(1, 10)) @(posedge clk);
				end
			end
		end
		pix_valid <= 1'b0;
	endtask

	// The block is idle once every expected beat has arrived and pixels of the first
	// row, which release nothing, have had time to leave the pipeline.
	task automatic settle();
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int random_count;
		int count;
		logic [APB_DATA_W-1:0] w_raw;
		logic [APB_DATA_W-1:0] h_raw;
		pixel_style_e style;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames.
		write_register(REG_IMAGE_WIDTH, 32'd0);
		write_register(REG_IMAGE_HEIGHT, 32'd1);
		foreach (DIRECTED_TINY[i]) pixel_queue.push_back(DIRECTED_TINY[i]);
		send_pixels();
		settle();
		write_register(REG_IMAGE_WIDTH, 32'd4);
		write_register(REG_IMAGE_HEIGHT, 32'd3);
		foreach (DIRECTED_4X3[i]) pixel_queue.push_back(DIRECTED_4X3[i]);
		send_pixels();

		// Random frames of small sizes. From the top left corner any size may be
		// chosen, and some frames are cut short, tall frames always. A cut frame is
		// then resized in the middle: the width may only shrink, so that no line
		// buffer entry left unwritten since reset can reach a result, and the height
		// is rewritten so that the frame ends soon, possibly wrapping to row zero.
		random_count = 0;
		while (random_count < RANDOM_PIXELS || !sb.at_origin()) begin
			settle();
			style = pixel_style_e'($urandom_range(0, 2));
			flat_level = pix_t'($urandom_range(0, 255));
			if (sb.at_origin()) begin
				case ($urandom_range(0, 7))
					0: w_raw = $urandom_range(0, 1);
					1: w_raw = 2;
					default: w_raw = $urandom_range(3, 9);
				endcase
				case ($urandom_range(0, 7))
					0: h_raw = $urandom_range(0, 1);
					1: h_raw = 32'hFFFF;
					default: h_raw = $urandom_range(2, 5);
				endcase
				write_register(REG_IMAGE_WIDTH, w_raw);
				write_register(REG_IMAGE_HEIGHT, h_raw);
				if (h_raw == 32'hFFFF || $urandom_range(0, 3) == 0)
					count = $urandom_range(1, 3 * sb.eff_width());
				else
					count = sb.eff_width() * sb.eff_height();
			end else begin
				if ($urandom_range(0, 1) == 1) begin
					if ($urandom_range(0, 4) == 0)
						w_raw = $urandom_range(0, 1);
					else
						w_raw = $urandom_range(2, sb.eff_width());
					write_register(REG_IMAGE_WIDTH, w_raw);
				end
				write_register(REG_IMAGE_HEIGHT, $urandom_range(0, 6));
				count = sb.pixels_to_frame_end();
			end
			queue_pixels(count, style);
			send_pixels();
			random_count += count;
		end

		settle();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/lmb_pkg.sv
hw/rtl/lmb_ram.sv
hw/rtl/lmb_judge.sv
hw/rtl/lmb_run_fifo.sv
hw/rtl/local_mean_binarize_3x3.sv
hw/rtl/lmb_checker.sv
sim/tb_local_mean_binarize_3x3.sv
